[hw/rtl/zfps_pkg.sv]
`timescale 1ns / 1ps

package zfps_pkg;

  localparam int REG_W = 52;
  localparam int LOW_W = 32;
  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_ADDR_BITS = 52;

  localparam logic [REG_W-1:0] LOW_LIMIT_RST = 52'h0_0001_0000_0000;
  localparam logic [REG_W-1:0] MID_LIMIT_RST = 52'h0_0010_0000_0000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ZONE_LOW  = 2'd0,
    ZONE_MID  = 2'd1,
    ZONE_HIGH = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    CLS_LOW = 2'd0,
    CLS_MID = 2'd1,
    CLS_ANY = 2'd2
  } class_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CFG_LOW_LIMIT = 2'd0,
    CFG_MID_LIMIT = 2'd1,
    CFG_WIDE_MODE = 2'd2
  } cfg_idx_t;

endpackage

[hw/rtl/zfps_ram.sv]
`timescale 1ns / 1ps

module zfps_ram
  import zfps_pkg::*;
#(
  parameter int WIDTH = REG_W,
  parameter int DEPTH = DEF_STACK_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/zoned_free_page_stack.sv]
`timescale 1ns / 1ps
// Channel   Direction  Transfer when            Contents
// in_       slave      in_tvalid & in_tready    tuser mode/class, tdata free address
// out_      master     out_tvalid & out_tready  tdata page address, tuser status/stack
// cfg_      slave      cfg_valid & cfg_ready    register index and data
//
// A free, and an allocate whose stack is still empty after falling back toward
// the low stack, capture the item, then decide the zone and update the count.
// An allocate that pops a page adds a step for the synchronous stack memory read.
// Reset clears the counts and the control state; stack contents are not cleared.
// A waiting result holds the block in its last step until out_tready is seen.

module zoned_free_page_stack
  import zfps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  localparam int DATA_W = ((ADDR_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // free_address
  input  logic [2:0]        in_tuser,   // mode, address_class
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // page_address
  output logic [3:0]        out_tuser,  // status, stack_used
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int EFF_W = (ADDR_BITS < REG_W) ? ADDR_BITS : REG_W;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [REG_W-1:0] low_limit_r, mid_limit_r;
  logic             wide_mode_r;

  mode_t            mode_r;
  logic [1:0]       cls_r;
  logic [EFF_W-1:0] addr_r;
  logic [REG_W-1:0] addr_ext;

  logic [CNT_W-1:0] low_cnt_r, mid_cnt_r, high_cnt_r;
  logic [CNT_W-1:0] sel_cnt, sel_cnt_dec;

  zone_t   ex_zone, zone_r;
  status_t ex_status;
  logic    ex_push, ex_pop, out_free, load_ex, load_rd;

  logic             out_valid_r;
  logic [EFF_W-1:0] out_page_r;
  status_t          out_status_r;
  zone_t            out_zone_r;

  logic [LOW_W-1:0] low_rd;
  logic [EFF_W-1:0] mid_rd, high_rd, rd_page;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign addr_ext  = REG_W'(addr_r);

  always_comb begin
    ex_zone   = ZONE_LOW;
    ex_status = ST_OK;
    if (mode_r == MODE_FREE) begin
      if (addr_ext < low_limit_r) begin
        ex_zone = ZONE_LOW;
      end else if (!wide_mode_r) begin
        ex_status = ST_IGNORED;
      end else if (addr_ext < mid_limit_r) begin
        ex_zone = ZONE_MID;
      end else begin
        ex_zone = ZONE_HIGH;
      end
    end else begin
      if (!wide_mode_r) begin
        ex_zone = ZONE_LOW;
      end else begin
        case (cls_r)
          CLS_LOW: ex_zone = ZONE_LOW;
          CLS_MID: ex_zone = ZONE_MID;
          default: ex_zone = ZONE_HIGH;
        endcase
      end
      if (ex_zone == ZONE_HIGH && high_cnt_r == '0) begin
        ex_zone = ZONE_MID;
      end
      if (ex_zone == ZONE_MID && mid_cnt_r == '0) begin
        ex_zone = ZONE_LOW;
      end
    end

    unique case (ex_zone)
      ZONE_MID:  sel_cnt = mid_cnt_r;
      ZONE_HIGH: sel_cnt = high_cnt_r;
      default:   sel_cnt = low_cnt_r;
    endcase

    if (mode_r == MODE_FREE) begin
      if (ex_status == ST_OK && sel_cnt >= CNT_W'(STACK_DEPTH)) begin
        ex_status = ST_FULL;
      end
    end else if (sel_cnt == '0) begin
      ex_status = ST_EMPTY;
      ex_zone   = ZONE_LOW;
    end
  end

  assign sel_cnt_dec = sel_cnt - CNT_W'(1);
  assign ex_push = (state_r == S_EXEC) && (mode_r == MODE_FREE) && (ex_status == ST_OK)
                   && out_free;
  assign ex_pop  = (state_r == S_EXEC) && (mode_r == MODE_ALLOC) && (ex_status == ST_OK);
  assign load_ex = (state_r == S_EXEC) && !ex_pop && out_free;
  assign load_rd = (state_r == S_READ) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (ex_pop) begin
          state_nxt = S_READ;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_limit_r <= LOW_LIMIT_RST;
      mid_limit_r <= MID_LIMIT_RST;
      wide_mode_r <= 1'b1;
      low_cnt_r   <= '0;
      mid_cnt_r   <= '0;
      high_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LOW_LIMIT: low_limit_r <= cfg_data;
          CFG_MID_LIMIT: mid_limit_r <= cfg_data;
          CFG_WIDE_MODE: wide_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ex_push || ex_pop) begin
        unique case (ex_zone)
          ZONE_MID:  mid_cnt_r  <= ex_push ? mid_cnt_r + CNT_W'(1) : sel_cnt_dec;
          ZONE_HIGH: high_cnt_r <= ex_push ? high_cnt_r + CNT_W'(1) : sel_cnt_dec;
          default:   low_cnt_r  <= ex_push ? low_cnt_r + CNT_W'(1) : sel_cnt_dec;
        endcase
      end
      if (load_ex || load_rd) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= mode_t'(in_tuser[0]);
      cls_r  <= in_tuser[2:1];
      addr_r <= in_tdata[EFF_W-1:0];
    end
    if (ex_pop) begin
      zone_r <= ex_zone;
    end
    if (load_ex) begin
      out_page_r   <= '0;
      out_status_r <= ex_status;
      out_zone_r   <= ex_zone;
    end else if (load_rd) begin
      out_page_r   <= rd_page;
      out_status_r <= ST_OK;
      out_zone_r   <= zone_r;
    end
  end

  always_comb begin
    unique case (zone_r)
      ZONE_MID:  rd_page = mid_rd;
      ZONE_HIGH: rd_page = high_rd;
      default:   rd_page = EFF_W'(low_rd);
    endcase
  end

  zfps_ram #(.WIDTH(LOW_W), .DEPTH(STACK_DEPTH)) u_low_ram (
    .clk     (clk),
    .wr_en   (ex_push && ex_zone == ZONE_LOW),
    .wr_addr (sel_cnt[IDX_W-1:0]),
    .wr_data (LOW_W'(addr_r)),
    .rd_en   (ex_pop && ex_zone == ZONE_LOW),
    .rd_addr (sel_cnt_dec[IDX_W-1:0]),
    .rd_data (low_rd)
  );

  zfps_ram #(.WIDTH(EFF_W), .DEPTH(STACK_DEPTH)) u_mid_ram (
    .clk     (clk),
    .wr_en   (ex_push && ex_zone == ZONE_MID),
    .wr_addr (sel_cnt[IDX_W-1:0]),
    .wr_data (addr_r),
    .rd_en   (ex_pop && ex_zone == ZONE_MID),
    .rd_addr (sel_cnt_dec[IDX_W-1:0]),
    .rd_data (mid_rd)
  );

  zfps_ram #(.WIDTH(EFF_W), .DEPTH(STACK_DEPTH)) u_high_ram (
    .clk     (clk),
    .wr_en   (ex_push && ex_zone == ZONE_HIGH),
    .wr_addr (sel_cnt[IDX_W-1:0]),
    .wr_data (addr_r),
    .rd_en   (ex_pop && ex_zone == ZONE_HIGH),
    .rd_addr (sel_cnt_dec[IDX_W-1:0]),
    .rd_data (high_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_page_r);
  assign out_tuser  = {out_zone_r, out_status_r};

endmodule

[hw/rtl/zfps_chk.sv]
`timescale 1ns / 1ps

module zfps_chk
  import zfps_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  localparam int DATA_W = ((ADDR_BITS + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [3:0]        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_EMPTY || out_tuser[1:0] == ST_FULL
                   || out_tuser[1:0] == ST_IGNORED) |-> out_tdata == '0)
    else $error("page address on a result that carries none");

  a_zone_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_EMPTY || out_tuser[1:0] == ST_IGNORED)
    |-> out_tuser[3:2] == ZONE_LOW)
    else $error("wrong stack reported");

endmodule

bind zoned_free_page_stack zfps_chk #(.ADDR_BITS(ADDR_BITS)) u_zfps_chk (.*);
